@@ src/mmsc_pkg.sv @@
// mmsc_pkg: shared constants, register codes and structs for the motion mask block
// no dependencies

package mmsc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int WDIM_W      = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W      = $clog2(MAX_HEIGHT + 1);

    localparam int PIX_W       = 8;
    localparam int DIM_W       = 11;
    localparam int MODE_W      = 2;
    localparam int SAD_W       = 28;
    localparam int LIMIT_W     = PIX_W + CNT_W;
    localparam int CMP_W       = SAD_W + LIMIT_W;
    localparam int IDX_W       = 3;
    localparam int CFG_DATA_W  = DIM_W;

    localparam logic [MODE_W-1:0] MODE_NEVER  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALWAYS = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_LOW_THRESHOLD    = 3'd0,
        REG_HIGH_THRESHOLD   = 3'd1,
        REG_MOTION_THRESHOLD = 3'd2,
        REG_SCENE_MODE       = 3'd3,
        REG_SCENE_FILL       = 3'd4,
        REG_FRAME_WIDTH      = 3'd5,
        REG_FRAME_HEIGHT     = 3'd6
    } reg_idx_t;

    // settings seen by the datapath
    typedef struct packed {
        logic [PIX_W-1:0]   low_threshold;
        logic [PIX_W-1:0]   high_threshold;
        logic [MODE_W-1:0]  scene_mode;
        logic [PIX_W-1:0]   scene_fill;
        logic [CNT_W-1:0]   total_m1;
        logic [LIMIT_W-1:0] limit;
        logic               settling;
    } cfg_t;

    // word in flight to the output stage
    typedef struct packed {
        logic valid;
        logic decision;
        logic scene;
        logic last;
    } stage_t;

endpackage

@@ src/mmsc_ram.sv @@
// mmsc_ram: generic single-port synchronous ram with registered read
// no dependencies

module mmsc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/mmsc_cfg.sv @@
// mmsc_cfg: configuration registers and derived frame size and motion limit
// depends on mmsc_pkg

module mmsc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mmsc_pkg::IDX_W-1:0]      cfg_index,
    input  logic [mmsc_pkg::CFG_DATA_W-1:0] cfg_data,
    output mmsc_pkg::cfg_t                 cfg
);

    logic [mmsc_pkg::PIX_W-1:0]   low_reg, low_next;
    logic [mmsc_pkg::PIX_W-1:0]   high_reg, high_next;
    logic [mmsc_pkg::PIX_W-1:0]   motion_reg, motion_next;
    logic [mmsc_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [mmsc_pkg::PIX_W-1:0]   fill_reg, fill_next;
    logic [mmsc_pkg::DIM_W-1:0]   width_reg, width_next;
    logic [mmsc_pkg::DIM_W-1:0]   height_reg, height_next;
    logic [1:0]                   settle_reg, settle_next;
    logic [mmsc_pkg::CNT_W-1:0]   total_reg;
    logic [mmsc_pkg::CNT_W-1:0]   total_m1_reg;
    logic [mmsc_pkg::LIMIT_W-1:0] limit_reg;
    logic [mmsc_pkg::WDIM_W-1:0]  width_clamped;
    logic [mmsc_pkg::HDIM_W-1:0]  height_clamped;
    logic                         wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    always_comb
    begin
        low_next    = low_reg;
        high_next   = high_reg;
        motion_next = motion_reg;
        mode_next   = mode_reg;
        fill_next   = fill_reg;
        width_next  = width_reg;
        height_next = height_reg;
        settle_next = (settle_reg != 2'd0) ? settle_reg - 2'd1 : 2'd0;
        if (wr)
        begin
            settle_next = 2'd2;
            case (mmsc_pkg::reg_idx_t'(cfg_index))
                mmsc_pkg::REG_LOW_THRESHOLD:    low_next    = cfg_data[mmsc_pkg::PIX_W-1:0];
                mmsc_pkg::REG_HIGH_THRESHOLD:   high_next   = cfg_data[mmsc_pkg::PIX_W-1:0];
                mmsc_pkg::REG_MOTION_THRESHOLD: motion_next = cfg_data[mmsc_pkg::PIX_W-1:0];
                mmsc_pkg::REG_SCENE_MODE:       mode_next   = cfg_data[mmsc_pkg::MODE_W-1:0];
                mmsc_pkg::REG_SCENE_FILL:       fill_next   = cfg_data[mmsc_pkg::PIX_W-1:0];
                mmsc_pkg::REG_FRAME_WIDTH:      width_next  = cfg_data;
                mmsc_pkg::REG_FRAME_HEIGHT:     height_next = cfg_data;
                default:                        settle_next = 2'd2;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg    <= '0;
            high_reg   <= '1;
            motion_reg <= '0;
            mode_reg   <= '0;
            fill_reg   <= '0;
            width_reg  <= mmsc_pkg::DIM_W'(1024);
            height_reg <= mmsc_pkg::DIM_W'(1024);
            settle_reg <= 2'd2;
        end
        else
        begin
            low_reg    <= low_next;
            high_reg   <= high_next;
            motion_reg <= motion_next;
            mode_reg   <= mode_next;
            fill_reg   <= fill_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            settle_reg <= settle_next;
        end
    end

    // zero counts as one, oversize counts as the maximum
    always_comb
    begin
        if (width_reg == '0)
            width_clamped = mmsc_pkg::WDIM_W'(1);
        else if (32'(width_reg) > mmsc_pkg::MAX_WIDTH)
            width_clamped = mmsc_pkg::WDIM_W'(mmsc_pkg::MAX_WIDTH);
        else
            width_clamped = mmsc_pkg::WDIM_W'(width_reg);

        if (height_reg == '0)
            height_clamped = mmsc_pkg::HDIM_W'(1);
        else if (32'(height_reg) > mmsc_pkg::MAX_HEIGHT)
            height_clamped = mmsc_pkg::HDIM_W'(mmsc_pkg::MAX_HEIGHT);
        else
            height_clamped = mmsc_pkg::HDIM_W'(height_reg);
    end

    // two multiplier stages, refreshed every cycle
    always_ff @(posedge clk)
    begin
        total_reg    <= mmsc_pkg::CNT_W'(width_clamped)
                        * mmsc_pkg::CNT_W'(height_clamped);
        total_m1_reg <= total_reg - mmsc_pkg::CNT_W'(1);
        limit_reg    <= mmsc_pkg::LIMIT_W'(motion_reg)
                        * mmsc_pkg::LIMIT_W'(total_reg);
    end

    always_comb
    begin
        cfg.low_threshold  = low_reg;
        cfg.high_threshold = high_reg;
        cfg.scene_mode     = mode_reg;
        cfg.scene_fill     = fill_reg;
        cfg.total_m1       = total_m1_reg;
        cfg.limit          = limit_reg;
        cfg.settling       = (settle_reg != 2'd0);
    end

endmodule

@@ src/mmsc_out.sv @@
// mmsc_out: mask thresholding and registered result word
// depends on mmsc_pkg

module mmsc_out (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mmsc_pkg::stage_t          stage,
    input  logic [mmsc_pkg::PIX_W-1:0] rdata,
    input  mmsc_pkg::cfg_t            cfg,
    output logic                      done,
    output logic                      is_decision,
    output logic                      scene_change,
    output logic [mmsc_pkg::PIX_W-1:0] mask_value,
    output logic                      last_pixel
);

    logic                       done_reg;
    logic                       decision_reg, decision_next;
    logic                       scene_reg, scene_next;
    logic [mmsc_pkg::PIX_W-1:0] mask_reg, mask_next;
    logic                       last_reg, last_next;

    always_comb
    begin
        decision_next = stage.decision;
        scene_next    = stage.scene;
        last_next     = stage.last & ~stage.decision;
        if (stage.decision)
            mask_next = '0;
        else if (stage.scene)
            mask_next = cfg.scene_fill;
        else if (rdata <= cfg.low_threshold)
            mask_next = '0;
        else if (rdata > cfg.high_threshold)
            mask_next = '1;
        else
            mask_next = rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= stage.valid;
    end

    always_ff @(posedge clk)
    begin
        decision_reg <= decision_next;
        scene_reg    <= scene_next;
        mask_reg     <= mask_next;
        last_reg     <= last_next;
    end

    assign done         = done_reg;
    assign is_decision  = decision_reg;
    assign scene_change = scene_reg;
    assign mask_value   = mask_reg;
    assign last_pixel   = last_reg;

endmodule

@@ src/motion_mask_scene_change.sv @@
// motion_mask_scene_change: frame-difference motion mask with scene-change detection
// a result strobes done once its accepted word has passed stage_reg and the mmsc_out output register
// throughput: one word per cycle while busy is low, loads and reads alike; the frame store is single port
// busy is high after reset and after each register write while the
// frame size and motion limit products settle; otherwise it stays low
// reset clears counters and flags and sets the registers to their defaults; the frame store holds no reset value
// depends on mmsc_pkg, mmsc_cfg, mmsc_ram, mmsc_out

module motion_mask_scene_change (
    input  logic                            clk,
    input  logic                            rst_n,
    // item word
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [mmsc_pkg::PIX_W-1:0]       cur_pixel,
    input  logic [mmsc_pkg::PIX_W-1:0]       ref_pixel,
    // result word, one cycle, no back pressure
    output logic                            done,
    output logic                            is_decision,
    output logic                            scene_change,
    output logic [mmsc_pkg::PIX_W-1:0]       mask_value,
    output logic                            last_pixel,
    // register write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mmsc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [mmsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mmsc_pkg::cfg_t cfg;

    mmsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // frame bookkeeping
    logic [mmsc_pkg::CNT_W-1:0] load_count_reg, load_count_next;
    logic [mmsc_pkg::CNT_W-1:0] read_count_reg, read_count_next;
    logic [mmsc_pkg::CNT_W-1:0] ready_m1_reg, ready_m1_next;
    logic [mmsc_pkg::SAD_W-1:0] sad_reg, sad_next;
    logic                       frame_ready_reg, frame_ready_next;
    logic                       scene_flag_reg, scene_flag_next;
    mmsc_pkg::stage_t           stage_reg, stage_next;

    logic                       accept;
    logic                       load_go;
    logic                       read_go;
    logic [mmsc_pkg::PIX_W-1:0] diff;
    logic [mmsc_pkg::SAD_W:0]   sad_sum_wide;
    logic [mmsc_pkg::SAD_W-1:0] sad_sat;
    logic                       frame_end;
    logic                       read_end;
    logic                       over_limit;
    logic                       verdict;

    logic                        ram_en;
    logic [mmsc_pkg::ADDR_W-1:0] ram_addr;
    logic [mmsc_pkg::PIX_W-1:0]  ram_rdata;

    assign busy    = cfg.settling;
    assign accept  = start & ~busy;
    assign load_go = accept & (kind == mmsc_pkg::KIND_LOAD);
    // a read with no frame ready is dropped
    assign read_go = accept & (kind == mmsc_pkg::KIND_READ) & frame_ready_reg;

    // absolute difference and saturating sad update
    assign diff         = (cur_pixel >= ref_pixel) ? cur_pixel - ref_pixel
                                                   : ref_pixel - cur_pixel;
    assign sad_sum_wide = {1'b0, sad_reg} + (mmsc_pkg::SAD_W + 1)'(diff);
    assign sad_sat      = sad_sum_wide[mmsc_pkg::SAD_W] ? '1
                                                        : sad_sum_wide[mmsc_pkg::SAD_W-1:0];

    // frame ends once load_count + 1 reaches the size, even if the size shrank mid-frame
    assign frame_end  = (load_count_reg >= cfg.total_m1);
    assign read_end   = (read_count_reg >= ready_m1_reg);
    assign over_limit = mmsc_pkg::CMP_W'(sad_sat) > mmsc_pkg::CMP_W'(cfg.limit);

    always_comb
    begin
        case (cfg.scene_mode)
            mmsc_pkg::MODE_ALWAYS: verdict = 1'b1;
            mmsc_pkg::MODE_NEVER:  verdict = 1'b0;
            default:               verdict = over_limit;
        endcase
    end

    always_comb
    begin
        load_count_next  = load_count_reg;
        read_count_next  = read_count_reg;
        ready_m1_next    = ready_m1_reg;
        sad_next         = sad_reg;
        frame_ready_next = frame_ready_reg;
        scene_flag_next  = scene_flag_reg;
        stage_next       = '0;

        if (load_go)
        begin
            // a new load drops any mask still pending
            frame_ready_next = 1'b0;
            read_count_next  = '0;
            if (frame_end)
            begin
                ready_m1_next       = load_count_reg;
                load_count_next     = '0;
                sad_next            = '0;
                scene_flag_next     = verdict;
                frame_ready_next    = 1'b1;
                stage_next.valid    = 1'b1;
                stage_next.decision = 1'b1;
                stage_next.scene    = verdict;
            end
            else
            begin
                load_count_next = load_count_reg + mmsc_pkg::CNT_W'(1);
                sad_next        = sad_sat;
            end
        end
        else if (read_go)
        begin
            stage_next.valid = 1'b1;
            stage_next.scene = scene_flag_reg;
            stage_next.last  = read_end;
            if (read_end)
            begin
                frame_ready_next = 1'b0;
                read_count_next  = '0;
            end
            else
            begin
                read_count_next = read_count_reg + mmsc_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg  <= '0;
            read_count_reg  <= '0;
            ready_m1_reg    <= '0;
            sad_reg         <= '0;
            frame_ready_reg <= 1'b0;
            scene_flag_reg  <= 1'b0;
            stage_reg       <= '0;
        end
        else
        begin
            load_count_reg  <= load_count_next;
            read_count_reg  <= read_count_next;
            ready_m1_reg    <= ready_m1_next;
            sad_reg         <= sad_next;
            frame_ready_reg <= frame_ready_next;
            scene_flag_reg  <= scene_flag_next;
            stage_reg       <= stage_next;
        end
    end

    // counts never pass the store depth, so the low bits address it directly
    assign ram_en   = load_go | read_go;
    assign ram_addr = load_go ? load_count_reg[mmsc_pkg::ADDR_W-1:0]
                              : read_count_reg[mmsc_pkg::ADDR_W-1:0];

    mmsc_ram #(
        .DEPTH (mmsc_pkg::STORE_DEPTH),
        .WIDTH (mmsc_pkg::PIX_W)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (load_go),
        .addr  (ram_addr),
        .wdata (diff),
        .rdata (ram_rdata)
    );

    // stored difference arrives with stage_reg; threshold and register the word
    mmsc_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage_reg),
        .rdata        (ram_rdata),
        .cfg          (cfg),
        .done         (done),
        .is_decision  (is_decision),
        .scene_change (scene_change),
        .mask_value   (mask_value),
        .last_pixel   (last_pixel)
    );

endmodule
